// ===== hw/rtl/gpd_pkg.sv =====
// ----------------------------------------------------------------------------
// gpd_pkg
// Shared types and constants for the genotype pair distance block.
// ----------------------------------------------------------------------------
package gpd_pkg;

  // Store geometry
  localparam int MAX_INDIVIDUALS = 256;
  localparam int MAX_LOCI        = 32;
  localparam int ALLELE_BITS     = 10;
  localparam int IND_BITS        = $clog2(MAX_INDIVIDUALS);
  localparam int LOC_BITS        = $clog2(MAX_LOCI);
  localparam int ADDR_BITS       = IND_BITS + LOC_BITS;
  localparam int DEPTH           = MAX_INDIVIDUALS * MAX_LOCI;

  // Field widths fixed by the interface
  localparam int IND_FIELD_BITS  = 8;
  localparam int LOC_FIELD_BITS  = 5;
  localparam int WEIGHT_BITS     = 8;
  localparam int COUNT_BITS      = 6;
  localparam int DIST_BITS       = 15;
  localparam int CFG_DATA_BITS   = 8;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int S_TDATA_BITS    = 48;
  localparam int M_TDATA_BITS    = 24;

  // Arithmetic widths
  localparam int PEN_BITS        = 17;
  localparam int SUM_BITS        = 17;

  // Fixed point constants, 4 fractional bits
  localparam int ONE_FIXED       = 16;
  localparam int OFFSET_FIXED    = 96;
  localparam int DIST_MAX        = 32767;
  localparam int COUNT_MAX       = 63;

  // Register reset values
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET  = 8'd16;
  localparam logic [COUNT_BITS-1:0]  MIN_RESET     = 6'd8;
  localparam logic [COUNT_BITS-1:0]  LOCI_RESET    = 6'd32;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MISSING_WEIGHT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SHARED     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOCI_IN_USE    = 2'd2;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                   m2;
    logic [ALLELE_BITS-1:0] a2;
    logic                   m1;
    logic [ALLELE_BITS-1:0] a1;
  } geno_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_MULT,
    ST_RESULT
  } state_t;

endpackage

// ===== hw/rtl/genotype_pair_distance.sv =====
// ----------------------------------------------------------------------------
// genotype_pair_distance
// Genotype store with a pairwise distance query over the loci in use.
// ----------------------------------------------------------------------------
// A load word is written into the store at the edge that accepts it. A query
// word walks one locus per cycle through the two read ports of the store over
// N = min(loci_in_use, 32) loci, then the drain, multiply and result states.
// Loads are taken one word per cycle while idle; a query holds the input until
// its result is registered, and longer while an earlier result is waiting.
// Reset clears the control state and loads the register defaults; the store
// itself is not cleared and holds whatever was last loaded.
// ----------------------------------------------------------------------------
module genotype_pair_distance (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [gpd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [gpd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // from bit 0: individual[7:0], partner[15:8], locus[20:16],
  // allele_one[30:21], allele_one_missing[31], allele_two[41:32],
  // allele_two_missing[42], zero fill[47:43]
  input  logic [gpd_pkg::S_TDATA_BITS-1:0]      s_axis_tdata,
  // operation[0]
  input  logic                                  s_axis_tuser,
  // Result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // from bit 0: distance[14:0], shared_loci[20:15], zero fill[23:21]
  output logic [gpd_pkg::M_TDATA_BITS-1:0]      m_axis_tdata,
  // below_minimum[0]
  output logic                                  m_axis_tuser
);
  import gpd_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. The user changes them only while the block is idle; the block does not enforce it.
  // --------------------------------------------------------------------------
  logic [WEIGHT_BITS-1:0] missing_weight;
  logic [COUNT_BITS-1:0]  min_shared_loci;
  logic [COUNT_BITS-1:0]  loci_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      missing_weight  <= WEIGHT_RESET;
      min_shared_loci <= MIN_RESET;
      loci_in_use     <= LOCI_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MISSING_WEIGHT: missing_weight  <= cfg_data[WEIGHT_BITS-1:0];
        CFG_MIN_SHARED:     min_shared_loci <= cfg_data[COUNT_BITS-1:0];
        CFG_LOCI_IN_USE:    loci_in_use     <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Loci walked by a query; values above the store's locus count are clamped.
  logic [COUNT_BITS-1:0] walk_loci;
  assign walk_loci = (loci_in_use > COUNT_BITS'(MAX_LOCI)) ?
                     COUNT_BITS'(MAX_LOCI) : loci_in_use;

  // --------------------------------------------------------------------------
  // Input word unpacking
  // --------------------------------------------------------------------------
  logic                      in_op;
  logic [IND_FIELD_BITS-1:0] in_individual;
  logic [IND_FIELD_BITS-1:0] in_partner;
  logic [LOC_FIELD_BITS-1:0] in_locus;
  geno_t                     in_geno;

  assign in_op               = s_axis_tuser;
  assign in_individual       = s_axis_tdata[7:0];
  assign in_partner          = s_axis_tdata[15:8];
  assign in_locus            = s_axis_tdata[20:16];
  assign in_geno.a1          = s_axis_tdata[30:21];
  assign in_geno.m1          = s_axis_tdata[31];
  assign in_geno.a2          = s_axis_tdata[41:32];
  assign in_geno.m2          = s_axis_tdata[42];

  logic in_accept;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_t state, state_next;

  logic [IND_BITS-1:0]   query_ind;
  logic [IND_BITS-1:0]   query_par;
  logic [COUNT_BITS-1:0] locus_cnt;
  logic                  rd_valid;
  logic                  issue_read;
  logic                  start_query;
  logic                  load_result;

  logic                  out_valid;

  // Next state and handshake. The store is written directly from the input
  // word on a load, so a load never leaves the idle state.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    issue_read    = 1'b0;
    start_query   = 1'b0;
    load_result   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && in_op == OP_QUERY) begin
          start_query = 1'b1;
          state_next  = (walk_loci == '0) ? ST_DRAIN : ST_READ;
        end
      end
      ST_READ: begin
        issue_read = 1'b1;
        if (locus_cnt == walk_loci - COUNT_BITS'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_MULT;
      end
      ST_MULT: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || m_axis_tready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locus_cnt <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= issue_read;
      if (start_query) begin
        locus_cnt <= '0;
      end else if (issue_read) begin
        locus_cnt <= locus_cnt + COUNT_BITS'(1);
      end
    end
  end

  // Individual numbers wrap on the store's individual count.
  always_ff @(posedge clk) begin
    if (in_accept && in_op == OP_QUERY) begin
      query_ind <= in_individual[IND_BITS-1:0];
      query_par <= in_partner[IND_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Genotype store: one write port, two registered read ports. Address is the
  // individual in the high bits and the locus in the low bits. A query only
  // starts reading the cycle after its acceptance, so a load just before it
  // has already landed and no forwarding is needed.
  // --------------------------------------------------------------------------
  geno_t store [DEPTH];

  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [ADDR_BITS-1:0] rd_addr_a;
  logic [ADDR_BITS-1:0] rd_addr_b;
  geno_t                rd_a;
  geno_t                rd_b;

  assign wr_en     = in_accept && (in_op == OP_LOAD) &&
                     ({1'b0, in_locus} < (LOC_FIELD_BITS + 1)'(MAX_LOCI));
  assign wr_addr   = {in_individual[IND_BITS-1:0], in_locus[LOC_BITS-1:0]};
  assign rd_addr_a = {query_ind, locus_cnt[LOC_BITS-1:0]};
  assign rd_addr_b = {query_par, locus_cnt[LOC_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= in_geno;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_read) begin
      rd_a <= store[rd_addr_a];
      rd_b <= store[rd_addr_b];
    end
  end

  // --------------------------------------------------------------------------
  // Per-locus classification and counters. Each locus is exactly one of:
  // some allele missing, fully typed and identical, fully typed mismatch.
  // --------------------------------------------------------------------------
  logic any_missing;
  logic same_geno;

  assign any_missing = rd_a.m1 || rd_a.m2 || rd_b.m1 || rd_b.m2;
  assign same_geno   = (rd_a.a1 == rd_b.a1) && (rd_a.a2 == rd_b.a2);

  logic [COUNT_BITS-1:0] shared_cnt;
  logic [COUNT_BITS-1:0] miss_cnt;
  logic [COUNT_BITS-1:0] mism_cnt;

  always_ff @(posedge clk) begin
    if (start_query) begin
      shared_cnt <= '0;
      miss_cnt   <= '0;
      mism_cnt   <= '0;
    end else if (rd_valid) begin
      if (any_missing) begin
        miss_cnt <= miss_cnt + COUNT_BITS'(1);
      end else if (same_geno) begin
        shared_cnt <= shared_cnt + COUNT_BITS'(1);
      end else begin
        mism_cnt <= mism_cnt + COUNT_BITS'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Distance. The two products are registered in the multiply state and the
  // selection and clamp follow in the result state.
  // --------------------------------------------------------------------------
  logic [PEN_BITS-1:0] penalty;
  logic [SUM_BITS-1:0] miss_prod;

  always_ff @(posedge clk) begin
    if (state == ST_MULT) begin
      penalty   <= (PEN_BITS'(missing_weight) + PEN_BITS'(OFFSET_FIXED))
                   * PEN_BITS'({walk_loci, 1'b0});
      miss_prod <= SUM_BITS'(missing_weight) * SUM_BITS'(miss_cnt);
    end
  end

  logic                  below;
  logic [SUM_BITS-1:0]   dist_raw;
  logic [DIST_BITS-1:0]  dist_sat;
  logic [COUNT_BITS-1:0] shared_sat;

  assign below    = !((query_ind != query_par) && (shared_cnt >= min_shared_loci));
  assign dist_raw = below ? SUM_BITS'(penalty)
                          : miss_prod + SUM_BITS'(mism_cnt) * SUM_BITS'(ONE_FIXED);
  assign dist_sat = (dist_raw > SUM_BITS'(DIST_MAX)) ? DIST_BITS'(DIST_MAX)
                                                     : dist_raw[DIST_BITS-1:0];
  // The count is at most the locus count and fits its field.
  assign shared_sat = shared_cnt;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [DIST_BITS-1:0]  out_distance;
  logic [COUNT_BITS-1:0] out_shared;
  logic                  out_below;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_distance <= dist_sat;
      out_shared   <= shared_sat;
      out_below    <= below;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(M_TDATA_BITS - DIST_BITS - COUNT_BITS)'(0), out_shared, out_distance};
  assign m_axis_tuser  = out_below;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the genotype pair distance block. A queue of load
// and query words feeds a bursty stream driver, and a monitor keeps its own
// genotype store and register copies to work out each query result. Results
// are compared field by field while the result side stalls on a pattern.
// ----------------------------------------------------------------------------
module testbench;

  import gpd_pkg::*;

  // One input word as the stimulus sees it. The genotype field keeps the
  // package layout, which matches the order of the allele fields in tdata.
  typedef struct packed {
    logic                       op;
    logic [IND_FIELD_BITS-1:0]  individual;
    logic [IND_FIELD_BITS-1:0]  partner;
    logic [LOC_FIELD_BITS-1:0]  locus;
    geno_t                      geno;
  } sample_word_t;

  // One query result, split into its fields.
  typedef struct packed {
    logic [DIST_BITS-1:0]  distance;
    logic [COUNT_BITS-1:0] shared;
    logic                  below;
  } pair_result_t;

  localparam int CYCLE_LIMIT  = 300000;
  // The longest query walks 32 loci, then drains, multiplies and registers its result;
  // loads leave no result behind, so the block is given this long before it is called idle.
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE    = 4;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // from bit 0: individual, partner, locus, allele_one, allele_one_missing,
  // allele_two, allele_two_missing, zero fill
  logic [S_TDATA_BITS-1:0]   s_axis_tdata = '0;
  // operation
  logic                      s_axis_tuser = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // from bit 0: distance, shared_loci, zero fill
  logic [M_TDATA_BITS-1:0]   m_axis_tdata;
  // below_minimum
  logic                      m_axis_tuser;

  genotype_pair_distance i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Words waiting for the driver, and query results waiting for the block.
  sample_word_t pending_words[$];
  pair_result_t expected_results[$];
  int           words_queued   = 0;
  int           words_accepted = 0;
  int           mismatch_count = 0;
  int           cycle_count    = 0;

  // The bench's own copy of the store and of the three registers.
  geno_t                  genotype_model [0:DEPTH-1];
  logic [WEIGHT_BITS-1:0] weight_model;
  logic [COUNT_BITS-1:0]  min_model;
  logic [COUNT_BITS-1:0]  loci_model;

  // Individuals used for random queries. Each one is a variant of a common
  // base profile, so pairs share enough loci to land on both sides of the
  // minimum. Every pool member has all 32 loci loaded before it is queried.
  geno_t       base_profile [0:MAX_LOCI-1];
  logic [7:0]  pool_id   [0:POOL_SIZE-1];
  int          pool_mut  [0:POOL_SIZE-1];
  int          pool_miss [0:POOL_SIZE-1];

  // Handshake bookkeeping for the driver and the result-side stall pattern.
  logic        word_taken = 1'b0;
  int          burst_left = 8;
  int          gap_left   = 0;
  logic [15:0] ready_pattern = '1;
  logic [3:0]  stall_pos = '0;

  // --------------------------------------------------------------------------
  // Distance predictor: walks the loci in use over the bench's store copy.
  // --------------------------------------------------------------------------
  function automatic pair_result_t pair_distance(logic [7:0] first, logic [7:0] other);
    pair_result_t r;
    int unsigned  n_loci;
    int unsigned  shared;
    int unsigned  missing;
    int unsigned  differ;
    int unsigned  total;
    geno_t        x;
    geno_t        y;
    logic         below;
    // Loci in use above the store depth act as the full depth; zero walks
    // nothing and yields a zero distance either way.
    n_loci  = (loci_model > MAX_LOCI) ? MAX_LOCI : loci_model;
    shared  = 0;
    missing = 0;
    differ  = 0;
    for (int k = 0; k < n_loci; k++) begin
      x = genotype_model[first * MAX_LOCI + k];
      y = genotype_model[other * MAX_LOCI + k];
      if (x.m1 || x.m2 || y.m1 || y.m2) begin
        missing++;
      end else if (x.a1 == y.a1 && x.a2 == y.a2) begin
        shared++;
      end else begin
        differ++;
      end
    end
    // A self query, or too few shared loci, gets the flat penalty.
    below = !(first != other && shared >= min_model);
    if (below) begin
      total = (weight_model + OFFSET_FIXED) * 2 * n_loci;
    end else begin
      total = weight_model * missing + ONE_FIXED * differ;
    end
    if (total > DIST_MAX) total = DIST_MAX;
    if (shared > COUNT_MAX) shared = COUNT_MAX;
    r.distance = total[DIST_BITS-1:0];
    r.shared   = shared[COUNT_BITS-1:0];
    r.below    = below;
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic geno_t genotype(logic [9:0] a1, logic m1, logic [9:0] a2, logic m2);
    geno_t g;
    g.a1 = a1;
    g.m1 = m1;
    g.a2 = a2;
    g.m2 = m2;
    return g;
  endfunction

  function automatic geno_t random_geno();
    logic [21:0] bits;
    bits = 22'($urandom);
    return bits;
  endfunction

  // A copy of the base profile at one locus, with a chance of a changed or
  // swapped allele and a chance of an unscored allele.
  function automatic geno_t variant_of(int loc, int mut_pct, int miss_pct);
    geno_t      g;
    logic [9:0] hold;
    g = base_profile[loc];
    if ($urandom_range(0, 99) < mut_pct) begin
      case ($urandom_range(0, 2))
        0: g.a1 = 10'($urandom);
        1: g.a2 = 10'($urandom);
        default: begin
          hold = g.a1;
          g.a1 = g.a2;
          g.a2 = hold;
        end
      endcase
    end
    if ($urandom_range(0, 99) < miss_pct) begin
      if ($urandom_range(0, 1) == 0) begin
        g.m1 = 1'b1;
      end else begin
        g.m2 = 1'b1;
      end
    end
    return g;
  endfunction

  function automatic void queue_load(logic [7:0] ind, logic [7:0] partner, logic [4:0] loc,
                                     geno_t g);
    sample_word_t w;
    w.op         = OP_LOAD;
    w.individual = ind;
    w.partner    = partner;
    w.locus      = loc;
    w.geno       = g;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // The locus and allele fields mean nothing to a query; they carry noise.
  function automatic void queue_query(logic [7:0] first, logic [7:0] other);
    sample_word_t w;
    w.op         = OP_QUERY;
    w.individual = first;
    w.partner    = other;
    w.locus      = 5'($urandom);
    w.geno       = random_geno();
    pending_words.push_back(w);
    words_queued++;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_registers(logic [7:0] weight, logic [5:0] min_shared, logic [5:0] loci);
    write_reg(CFG_MISSING_WEIGHT, weight);
    write_reg(CFG_MIN_SHARED, {2'b00, min_shared});
    write_reg(CFG_LOCI_IN_USE, {2'b00, loci});
  endtask

  // Idle means every word taken, every result back, and a quiet tail long
  // enough for a trailing load or query to finish inside the block.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (words_accepted != words_queued || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register setting followed by a random mix: mostly pool queries, some
  // single-locus reloads of pool members, and a little noise elsewhere.
  task automatic run_phase(logic [7:0] weight, logic [5:0] min_shared, logic [5:0] loci,
                           int count);
    int         pick;
    int         m;
    int         loc;
    logic [7:0] first;
    logic [7:0] other;
    set_registers(weight, min_shared, loci);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        first = pool_id[$urandom_range(0, POOL_SIZE - 1)];
        other = ($urandom_range(0, 9) == 0) ? first : pool_id[$urandom_range(0, POOL_SIZE - 1)];
        queue_query(first, other);
      end else if (pick < 92) begin
        m   = $urandom_range(0, POOL_SIZE - 1);
        loc = $urandom_range(0, MAX_LOCI - 1);
        queue_load(pool_id[m], 8'($urandom), 5'(loc),
                   variant_of(loc, pool_mut[m], pool_miss[m]));
      end else begin
        queue_load(8'($urandom), 8'($urandom), 5'($urandom), random_geno());
      end
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents one word at a time in bursts of random length separated
  // by random gaps. About a quarter of the gaps are zero, so bursts also run
  // back to back.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_words
    sample_word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        s_axis_tdata  <= {5'b00000, w.geno, w.locus, w.partner, w.individual};
        s_axis_tuser  <= w.op;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result-side stalls: a 16-bit ready pattern, reloaded each time it wraps.
  // Some patterns are all ready, some random, some mostly ready, and some hold
  // the result back in every position but the first.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : stall_results
    logic [15:0] pat;
    if (stall_pos == 0) begin
      case ($urandom_range(0, 3))
        0: pat = '1;
        1: pat = 16'($urandom);
        2: pat = 16'($urandom | $urandom);
        default: pat = 16'h0001;
      endcase
    end else begin
      pat = ready_pattern;
    end
    ready_pattern <= pat;
    m_axis_tready <= pat[stall_pos];
    stall_pos     <= stall_pos + 4'd1;
  end

  // --------------------------------------------------------------------------
  // Monitor: follows register writes, applies loads to the store copy,
  // predicts each accepted query, and checks each accepted result against the
  // oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : observe
    pair_result_t got;
    pair_result_t want;
    if (rst) begin
      weight_model = WEIGHT_RESET;
      min_model    = MIN_RESET;
      loci_model   = LOCI_RESET;
      word_taken  <= 1'b0;
    end else begin
      word_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MISSING_WEIGHT: weight_model = cfg_data;
          CFG_MIN_SHARED:     min_model    = cfg_data[COUNT_BITS-1:0];
          CFG_LOCI_IN_USE:    loci_model   = cfg_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.distance = m_axis_tdata[14:0];
        got.shared   = m_axis_tdata[20:15];
        got.below    = m_axis_tuser;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual distance %0d shared %0d below %0b",
                   $time, got.distance, got.shared, got.below);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("distance", want.distance, got.distance);
          compare_field("shared_loci", want.shared, got.shared);
          compare_field("below_minimum", want.below, got.below);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        words_accepted++;
        if (s_axis_tuser == OP_LOAD) begin
          genotype_model[s_axis_tdata[7:0] * MAX_LOCI + s_axis_tdata[20:16]] = s_axis_tdata[42:21];
        end else begin
          expected_results.push_back(pair_distance(s_axis_tdata[7:0], s_axis_tdata[15:8]));
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] cand;
    logic       clash;
    int         filled;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Only two loci are in use, so individuals 0 and 255 need
    // just loci 0 and 1 loaded before they can be queried.
    set_registers(8'd255, 6'd1, 6'd2);
    queue_load(8'd0,   8'd255, 5'd0,  genotype(10'd0,    1'b0, 10'd0,    1'b0));
    queue_load(8'd0,   8'd0,   5'd1,  genotype(10'd1023, 1'b0, 10'd1023, 1'b0));
    queue_load(8'd255, 8'd0,   5'd0,  genotype(10'd0,    1'b0, 10'd0,    1'b0));
    queue_load(8'd255, 8'd255, 5'd1,  genotype(10'd1023, 1'b1, 10'd1023, 1'b1));
    // Highest locus, outside the loci in use.
    queue_load(8'd255, 8'd0,   5'd31, genotype(10'd1023, 1'b0, 10'd0,    1'b0));
    // One shared locus and one with both alleles unscored: full weight once.
    queue_query(8'd0, 8'd255);
    // Self queries always take the penalty.
    queue_query(8'd0, 8'd0);
    queue_query(8'd255, 8'd255);
    // Fully typed mismatch at locus 1, then the same alleles in swapped order.
    queue_load(8'd255, 8'd0, 5'd1, genotype(10'd1023, 1'b0, 10'd1022, 1'b0));
    queue_query(8'd255, 8'd0);
    queue_load(8'd0, 8'd255, 5'd1, genotype(10'd1022, 1'b0, 10'd1023, 1'b0));
    queue_query(8'd0, 8'd255);
    wait_idle();
    // Too few shared loci with a zero weight: penalty of the offset alone.
    set_registers(8'd0, 6'd2, 6'd2);
    queue_query(8'd0, 8'd255);
    wait_idle();
    // One locus in use and no minimum.
    set_registers(8'd255, 6'd0, 6'd1);
    queue_query(8'd0, 8'd255);
    queue_query(8'd255, 8'd255);
    wait_idle();
    // No loci in use: nothing is compared and the distance is zero.
    set_registers(8'd128, 6'd0, 6'd0);
    queue_query(8'd255, 8'd0);
    wait_idle();
    // A minimum above the loci in use always gives the penalty.
    set_registers(8'd128, 6'd5, 6'd2);
    queue_query(8'd255, 8'd0);
    wait_idle();

    // Random part: build the base profile and the pool, then load every
    // locus of every pool member.
    for (int k = 0; k < MAX_LOCI; k++) begin
      base_profile[k] = genotype(10'($urandom), 1'b0, 10'($urandom), 1'b0);
      if ($urandom_range(0, 9) < 3) base_profile[k].a2 = base_profile[k].a1;
    end
    filled = 0;
    while (filled < POOL_SIZE) begin
      cand  = 8'($urandom_range(1, 254));
      clash = 1'b0;
      for (int m = 0; m < filled; m++) begin
        if (pool_id[m] == cand) clash = 1'b1;
      end
      if (!clash) begin
        pool_id[filled]   = cand;
        pool_mut[filled]  = $urandom_range(0, 30);
        pool_miss[filled] = $urandom_range(0, 12);
        filled++;
      end
    end
    for (int m = 0; m < POOL_SIZE; m++) begin
      for (int k = 0; k < MAX_LOCI; k++) begin
        queue_load(pool_id[m], 8'($urandom), 5'(k), variant_of(k, pool_mut[m], pool_miss[m]));
      end
    end
    wait_idle();

    run_phase(8'd16,  6'd8,  6'd32, 28);
    run_phase(8'd0,   6'd0,  6'd32, 28);
    run_phase(8'd255, 6'd32, 6'd32, 28);
    run_phase(8'd255, 6'd0,  6'd1,  28);
    run_phase(8'd40,  6'd3,  6'd5,  28);
    // Loci in use beyond the store depth act as the full depth.
    run_phase(8'd7,   6'd20, 6'd63, 28);
    run_phase(8'd100, 6'd32, 6'd16, 28);
    run_phase(8'($urandom), 6'($urandom_range(0, 32)), 6'($urandom_range(1, 32)), 28);
    run_phase(8'($urandom), 6'($urandom_range(0, 32)), 6'($urandom_range(1, 32)), 28);
    run_phase(8'($urandom), 6'($urandom_range(10, 28)), 6'd32, 28);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
